// ----- rtl/core/snat_pkg.sv -----
`default_nettype none
package snat_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam int ADDR_W = 32;
	localparam int CSUM_W = 16;
	localparam int MODE_W = 2;
	localparam int ACT_W = 5;
	localparam int HIT_IDX_W = 4;

	localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INBOUND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_OUTBOUND = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] ins_addr;
		logic [ADDR_W-1:0] outs_addr;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_CSUM = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	// Ones' complement add of one halfword with end-around carry.
	function automatic logic [CSUM_W-1:0] oc_add(input logic [CSUM_W-1:0] a,
		input logic [CSUM_W-1:0] b);
		logic [CSUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CSUM_W-1:0] + {{(CSUM_W-1){1'b0}}, s[CSUM_W]};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/snat_ifs.sv -----
`default_nettype none
interface snat_item_if;
	import snat_pkg::*;
	logic valid;
	logic ready;
	logic [MODE_W-1:0] mode;
	logic [3:0] entry_index;
	logic [ADDR_W-1:0] inside_addr;
	logic [ADDR_W-1:0] outside_addr;
	logic [ADDR_W-1:0] src_addr;
	logic [ADDR_W-1:0] dst_addr;
	logic [CSUM_W-1:0] header_checksum;

	modport source (output valid, mode, entry_index, inside_addr, outside_addr,
		src_addr, dst_addr, header_checksum, input ready);
	modport sink (input valid, mode, entry_index, inside_addr, outside_addr,
		src_addr, dst_addr, header_checksum, output ready);
	modport mon (input valid, ready, mode, entry_index, inside_addr, outside_addr,
		src_addr, dst_addr, header_checksum);
endinterface

interface snat_result_if;
	import snat_pkg::*;
	logic valid;
	logic ready;
	logic [ADDR_W-1:0] new_src_addr;
	logic [ADDR_W-1:0] new_dst_addr;
	logic [CSUM_W-1:0] new_checksum;
	logic hit;
	logic [HIT_IDX_W-1:0] hit_index;

	modport source (output valid, new_src_addr, new_dst_addr, new_checksum, hit,
		hit_index, input ready);
	modport sink (input valid, new_src_addr, new_dst_addr, new_checksum, hit,
		hit_index, output ready);
	modport mon (input valid, ready, new_src_addr, new_dst_addr, new_checksum, hit,
		hit_index);
endinterface

interface snat_cfg_if;
	import snat_pkg::*;
	logic valid;
	logic ready;
	logic [ACT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
	modport mon (input valid, ready, data);
endinterface
`default_nettype wire

// ----- rtl/core/snat_ram.sv -----
`default_nettype none
module snat_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/static_nat_address_rewrite.sv -----
// Flow, accept to result valid: a load item, mode three, or a lookup with no active
//   entry goes straight to done; a lookup that misses scans all n active entries;
//   a lookup that hits at entry k scans up to k, then runs four checksum adds.
// Items: one in flight; a new item is taken only in the idle state, once the result
//   is registered; the table scan reads one entry a cycle from the table RAM's single read port.
// Reset: arst_n clears sequencer, active count and output valid; table stays undefined.
`default_nettype none
module static_nat_address_rewrite (
	input wire logic clk,
	input wire logic arst_n,
	snat_item_if.sink item,
	snat_result_if.source result,
	snat_cfg_if.sink cfg
);
	import snat_pkg::*;

	state_t state_q;
	logic [ACT_W-1:0] active_q;

	// Item context held for the whole lookup
	logic [MODE_W-1:0] mode_q;
	logic [ADDR_W-1:0] src_q;
	logic [ADDR_W-1:0] dst_q;
	logic [CSUM_W-1:0] hc_q;
	logic hit_q;
	logic [IDX_W-1:0] hit_idx_q;

	// Scan control
	logic [CNT_W-1:0] rd_ptr_q;
	logic cmp_v_q;
	logic [IDX_W-1:0] cmp_idx_q;

	// Checksum sequencer
	logic [ADDR_W-1:0] old_q;
	logic [ADDR_W-1:0] new_q;
	logic [1:0] step_q;
	logic [CSUM_W-1:0] acc_q;

	// Output register
	logic res_valid_q;
	logic [ADDR_W-1:0] res_src_q;
	logic [ADDR_W-1:0] res_dst_q;
	logic [CSUM_W-1:0] res_hc_q;
	logic res_hit_q;
	logic [HIT_IDX_W-1:0] res_idx_q;

	logic item_acc;
	logic [CNT_W-1:0] n_cnt;
	logic issue;
	logic is_lookup;
	logic tbl_we;
	entry_t tbl_wdata;
	entry_t tbl_rdata;
	logic inbound_q;
	logic key_eq;
	logic match;
	logic [CSUM_W-1:0] opnd;
	logic [CSUM_W-1:0] acc_d;
	logic res_free;

	assign cfg.ready = 1'b1;
	assign item.ready = (state_q == ST_IDLE);
	assign item_acc = item.valid && item.ready;

	// Clamp the active count to the table depth
	assign n_cnt = (32'(active_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(active_q);

	assign is_lookup = (item.mode == MODE_INBOUND) || (item.mode == MODE_OUTBOUND);

	// Load slots past the table are dropped
	assign tbl_we = item_acc && (item.mode == MODE_LOAD)
		&& (32'(item.entry_index) < TABLE_DEPTH);
	assign tbl_wdata = '{ins_addr: item.inside_addr, outs_addr: item.outside_addr};

	assign issue = (state_q == ST_SCAN) && (rd_ptr_q < n_cnt);

	snat_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk(clk),
		.we(tbl_we),
		.waddr(IDX_W'(item.entry_index)),
		.wdata(tbl_wdata),
		.re(issue),
		.raddr(rd_ptr_q[IDX_W-1:0]),
		.rdata(tbl_rdata)
	);

	// Inbound matches the destination on the outside half, outbound the source
	// on the inside half.
	assign inbound_q = (mode_q == MODE_INBOUND);
	assign key_eq = inbound_q ? (tbl_rdata.outs_addr == dst_q) : (tbl_rdata.ins_addr == src_q);
	assign match = (state_q == ST_SCAN) && cmp_v_q && key_eq;

	// Shared ones' complement adder: one halfword per step, after ~HC seeds the sum
	always_comb begin
		case (step_q)
			2'd0: opnd = ~old_q[ADDR_W-1:CSUM_W];
			2'd1: opnd = ~old_q[CSUM_W-1:0];
			2'd2: opnd = new_q[ADDR_W-1:CSUM_W];
			2'd3: opnd = new_q[CSUM_W-1:0];
			default: opnd = '0;
		endcase
	end
	assign acc_d = oc_add(acc_q, opnd);

	assign res_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= '0;
			cmp_v_q <= 1'b0;
			rd_ptr_q <= '0;
			step_q <= '0;
			hit_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				active_q <= cfg.data;
			end

			if (state_q == ST_DONE && res_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						hit_q <= 1'b0;
						rd_ptr_q <= '0;
						cmp_v_q <= 1'b0;
						step_q <= '0;
						if (is_lookup && (n_cnt != '0)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					// Advance the read pointer; the compare follows in the cycle after each read
					cmp_v_q <= issue;
					if (issue) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					if (match) begin
						hit_q <= 1'b1;
						cmp_v_q <= 1'b0;
						state_q <= ST_CSUM;
					end else if (!issue) begin
						state_q <= ST_DONE;
					end
				end
				ST_CSUM: begin
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (item_acc) begin
			mode_q <= item.mode;
			src_q <= item.src_addr;
			dst_q <= item.dst_addr;
			hc_q <= item.header_checksum;
			hit_idx_q <= '0;
			acc_q <= ~item.header_checksum;
		end
		if (match) begin
			hit_idx_q <= cmp_idx_q;
			old_q <= inbound_q ? dst_q : src_q;
			new_q <= inbound_q ? tbl_rdata.ins_addr : tbl_rdata.outs_addr;
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_q <= rd_ptr_q[IDX_W-1:0];
		end
		if (state_q == ST_CSUM) begin
			acc_q <= acc_d;
			if (step_q == 2'd3) begin
				hc_q <= ~acc_d;
				if (inbound_q) begin
					dst_q <= new_q;
				end else begin
					src_q <= new_q;
				end
			end
		end
		if (state_q == ST_DONE && res_free) begin
			res_src_q <= src_q;
			res_dst_q <= dst_q;
			res_hc_q <= hc_q;
			res_hit_q <= hit_q;
			res_idx_q <= HIT_IDX_W'(hit_idx_q);
		end
	end

	assign result.valid = res_valid_q;
	assign result.new_src_addr = res_src_q;
	assign result.new_dst_addr = res_dst_q;
	assign result.new_checksum = res_hc_q;
	assign result.hit = res_hit_q;
	assign result.hit_index = res_idx_q;

endmodule
`default_nettype wire

// ----- rtl/core/snat_chk.sv -----
`default_nettype none
module snat_chk (
	input wire logic clk,
	input wire logic arst_n,
	snat_item_if.sink item,
	snat_result_if.source result,
	snat_cfg_if.sink cfg
);
	// Hold a stalled result word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> $stable(result.new_src_addr)
			&& $stable(result.new_dst_addr) && $stable(result.new_checksum)
			&& $stable(result.hit) && $stable(result.hit_index))
		else $error("stalled result word changed");

	// One item in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item accepted while a lookup is in flight");

	// A miss reports index zero
	a_miss_idx: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.hit |-> result.hit_index == '0)
		else $error("nonzero hit index on a miss");

	// Configuration writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |-> cfg.ready)
		else $error("configuration write stalled");
endmodule

bind static_nat_address_rewrite snat_chk u_snat_chk (
	.clk(clk),
	.arst_n(arst_n),
	.item(item),
	.result(result),
	.cfg(cfg)
);
`default_nettype wire
